@@ rtl/bdq_pkg.sv @@
package bdq_pkg;

  localparam int DATA_W = 32;
  localparam int OUT_CNT_W = 7;

  // operation codes after classification
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT = 3'd2;
  localparam logic [2:0] OP_POP_BACK  = 3'd3;
  localparam logic [2:0] OP_DEL_FIRST = 3'd4;
  localparam logic [2:0] OP_DEL_ALL   = 3'd5;
  localparam logic [2:0] OP_PEEK      = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] NONE_VALUE = '1;

  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] key;
  } cmd_t;

endpackage

@@ rtl/bdq_front.sv @@
module bdq_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_mode,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_key,
  output logic                              cmd_valid,
  output bdq_pkg::cmd_t                     cmd,
  input  logic                              cmd_take
);
  import bdq_pkg::*;

  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT = 3'd2;
  localparam logic [2:0] MODE_POP_BACK  = 3'd3;
  localparam logic [2:0] MODE_DEL_FIRST = 3'd4;
  localparam logic [2:0] MODE_DEL_ALL   = 3'd5;

  cmd_t       q_r [2];
  logic       head_r, head_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  logic       tail;
  cmd_t       in_cmd;

  // classify the incoming word; unused codes behave as a peek
  always_comb begin
    in_cmd.key = in_key;
    unique case (in_mode)
      MODE_INS_FRONT: in_cmd.op = OP_INS_FRONT;
      MODE_INS_BACK:  in_cmd.op = OP_INS_BACK;
      MODE_POP_FRONT: in_cmd.op = OP_POP_FRONT;
      MODE_POP_BACK:  in_cmd.op = OP_POP_BACK;
      MODE_DEL_FIRST: in_cmd.op = OP_DEL_FIRST;
      MODE_DEL_ALL:   in_cmd.op = OP_DEL_ALL;
      default:        in_cmd.op = OP_PEEK;
    endcase
  end

  // two-entry command queue
  assign busy      = (fill_r == 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[head_r];
  assign push      = start && !busy;
  assign pop       = cmd_take && cmd_valid;
  assign tail      = head_r ^ (fill_r == 2'd1);

  always_comb begin
    head_nxt = pop ? ~head_r : head_r;
    fill_nxt = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail] <= in_cmd;
    end
  end

endmodule

@@ rtl/bdq_back.sv @@
module bdq_back #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cmd_valid,
  input  bdq_pkg::cmd_t                        cmd,
  output logic                                 cmd_take,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]    out_removed_value,
  output logic [bdq_pkg::OUT_CNT_W-1:0]        out_removed_count,
  output logic signed [bdq_pkg::DATA_W-1:0]    out_front_value,
  output logic signed [bdq_pkg::DATA_W-1:0]    out_back_value,
  output logic [bdq_pkg::OUT_CNT_W-1:0]        out_entry_count
);
  import bdq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] S_OP   = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [DATA_W-1:0] rm_val_r, rm_val_nxt;
  logic [CNT_W-1:0]  rm_cnt_r, rm_cnt_nxt;
  logic [CNT_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic              pend_r, pend_nxt;
  logic              found_r, found_nxt;
  logic              valid_r, valid_nxt;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              rd_a_en, rd_b_en;
  logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;
  logic [DATA_W-1:0] rd_a_q, rd_b_q;

  logic [IDX_W-1:0]  front_dec, front_inc;
  logic [CNT_W-1:0]  back_pos;
  logic              is_full, is_empty, drop;

  // physical slot of a logical position below twice the capacity
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] pos);
    logic [CNT_W+1:0] sum;
    sum = {{(CNT_W+2-IDX_W){1'b0}}, base} + {2'b00, pos};
    if (sum >= (CNT_W+2)'(CAPACITY)) begin
      sum = sum - (CNT_W+2)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign is_full   = (count_r == FULL_CNT);
  assign is_empty  = (count_r == '0);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
  assign back_pos  = is_empty ? '0 : count_r - 1'b1;
  assign drop      = (rd_a_q == key_r) && ((op_r == OP_DEL_ALL) || !found_r);

  // sequencer: operate, walk for key deletes, read back front and back
  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    rm_val_nxt = rm_val_r;
    rm_cnt_nxt = rm_cnt_r;
    rd_pos_nxt = rd_pos_r;
    wr_pos_nxt = wr_pos_r;
    pend_nxt   = pend_r;
    found_nxt  = found_r;
    valid_nxt  = 1'b0;
    cmd_take   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = slot_of(front_r, wr_pos_r);
    mem_wdata  = rd_a_q;
    rd_a_en    = 1'b0;
    rd_b_en    = 1'b0;
    rd_a_addr  = slot_of(front_r, rd_pos_r);
    rd_b_addr  = slot_of(front_r, back_pos);
    unique case (state_r)
      S_OP: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          op_nxt     = cmd.op;
          key_nxt    = cmd.key;
          status_nxt = ST_OK;
          rm_val_nxt = NONE_VALUE;
          rm_cnt_nxt = '0;
          state_nxt  = S_RD;
          unique case (cmd.op)
            OP_INS_FRONT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_dec;
                mem_wdata = cmd.key;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_INS_BACK: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(front_r, count_r);
                mem_wdata = cmd.key;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rm_val_nxt = rd_a_q;
                rm_cnt_nxt = CNT_W'(1);
                front_nxt  = front_inc;
                count_nxt  = count_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rm_val_nxt = rd_b_q;
                rm_cnt_nxt = CNT_W'(1);
                count_nxt  = count_r - 1'b1;
              end
            end
            OP_DEL_FIRST, OP_DEL_ALL: begin
              if (!is_empty) begin
                rd_pos_nxt = '0;
                wr_pos_nxt = '0;
                pend_nxt   = 1'b0;
                found_nxt  = 1'b0;
                state_nxt  = S_WALK;
              end
            end
            default: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        // read one entry a cycle, write back the kept ones compacted
        if (rd_pos_r != count_r) begin
          rd_a_en    = 1'b1;
          rd_pos_nxt = rd_pos_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (drop) begin
            found_nxt = 1'b1;
          end else begin
            mem_we     = 1'b1;
            wr_pos_nxt = wr_pos_r + 1'b1;
          end
        end else if (rd_pos_r == count_r) begin
          count_nxt  = wr_pos_r;
          rm_cnt_nxt = count_r - wr_pos_r;
          rm_val_nxt = (count_r != wr_pos_r) ? key_r : NONE_VALUE;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        rd_a_en   = 1'b1;
        rd_b_en   = 1'b1;
        rd_a_addr = front_r;
        valid_nxt = 1'b1;
        state_nxt = S_OP;
      end
      default: begin
        state_nxt = S_OP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_OP;
      front_r <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      found_r <= found_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    rm_val_r <= rm_val_nxt;
    rm_cnt_r <= rm_cnt_nxt;
    rd_pos_r <= rd_pos_nxt;
    wr_pos_r <= wr_pos_nxt;
  end

  // value store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_a_en) begin
      rd_a_q <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_q <= mem[rd_b_addr];
    end
  end

  // result word, stable for the strobe cycle
  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_removed_value = rm_val_r;
  assign out_removed_count = OUT_CNT_W'(rm_cnt_r);
  assign out_front_value   = is_empty ? NONE_VALUE : rd_a_q;
  assign out_back_value    = is_empty ? NONE_VALUE : rd_b_q;
  assign out_entry_count   = OUT_CNT_W'(count_r);

endmodule

@@ rtl/bounded_deque_with_key_delete.sv @@
// Bounded double-ended queue of signed 32-bit values with delete by key.
// Command channel: drive in_mode and in_key with start high; the word is
// taken at a rising edge where start is high and busy is low. A two-word
// command queue sits in front of the execution engine, so busy only rises
// when two words are waiting.
// Result channel: out_valid is high for exactly one cycle per command with
// status, removed value and count, front and back values and entry count.
// The receiver cannot stall the result; it must take it in that cycle.
// An end insert, pop or peek reaching an idle engine passes an operate state
// and a read-back of front and back before its result is registered; the
// engine takes the next command only after that read-back.
// Key deletes on a non-empty store walk it one entry per cycle through the
// single walk read port and then read back front and back; on an
// empty store they go straight to the read-back like a peek.
// Reset (synchronous, rst_n low) empties the queue and the command queue;
// store contents are not cleared; an empty store shows no front or back value.
module bounded_deque_with_key_delete #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           in_mode,
  input  logic signed [bdq_pkg::DATA_W-1:0]    in_key,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]    out_removed_value,
  output logic [bdq_pkg::OUT_CNT_W-1:0]        out_removed_count,
  output logic signed [bdq_pkg::DATA_W-1:0]    out_front_value,
  output logic signed [bdq_pkg::DATA_W-1:0]    out_back_value,
  output logic [bdq_pkg::OUT_CNT_W-1:0]        out_entry_count
);
  import bdq_pkg::*;

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // command intake and classification
  bdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_mode   (in_mode),
    .in_key    (in_key),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // execution engine with the value store
  bdq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_take          (cmd_take),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_removed_count (out_removed_count),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_entry_count   (out_entry_count)
  );

  // results never come in back-to-back cycles
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe in two consecutive cycles");

  // a rejected insert removes nothing and leaves the store full
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |->
      (out_removed_count == '0 && out_entry_count == OUT_CNT_W'(CAPACITY)))
    else $error("full status with inconsistent counts");

  // an empty result shows no front or back and removes nothing
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |->
      (out_front_value == -32'sd1 && out_back_value == -32'sd1 &&
       out_removed_count == '0 && out_entry_count == '0))
    else $error("empty status with stale contents");

  // the command queue is open right after reset
  a_reset_open: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !busy)
    else $error("busy right after reset");

endmodule
